FILE: hw/rtl/iirtdf2_pkg.sv
package iirtdf2_pkg;

    localparam int MAX_ORDER   = 8;
    localparam int SAMPLE_BITS = 16;
    localparam int COEF_BITS   = 32;
    localparam int TAP_BITS    = 48;
    localparam int FRAC_BITS   = 24;
    localparam int FUNC_BITS   = 3;
    localparam int SLOT_BITS   = 4;
    localparam int ORDER_BITS  = 4;

    localparam int PROD_BITS = COEF_BITS + SAMPLE_BITS;
    localparam int SUM_BITS  = ((PROD_BITS > TAP_BITS) ? PROD_BITS : TAP_BITS) + 2;
    localparam int QUO_BITS  = SUM_BITS - FRAC_BITS;
    localparam int CMP_BITS  = SLOT_BITS + 1;

    localparam logic [ORDER_BITS-1:0] ORDER_RESET = ORDER_BITS'(2);

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_TAP    = 1'b1;

    typedef enum logic [FUNC_BITS-1:0] {
        FUNC_FILTER = 3'd0,
        FUNC_WR_B   = 3'd1,
        FUNC_WR_A   = 3'd2,
        FUNC_WR_TAP = 3'd3,
        FUNC_RD_TAP = 3'd4
    } t_func;

    typedef struct packed {
        logic we_b;
        logic we_a;
        logic we_z;
        logic mul_x;
        logic mul_y;
        logic update;
        logic active;
        logic last;
    } t_cell_ctrl;

    typedef struct packed {
        logic we_b0;
        logic mul_x;
        logic calc_y;
    } t_head_ctrl;

endpackage

FILE: hw/rtl/iirtdf2_cell.sv
module iirtdf2_cell (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  iirtdf2_pkg::t_cell_ctrl                   i_ctrl,
    input  logic signed [iirtdf2_pkg::COEF_BITS-1:0]  i_coef,
    input  logic signed [iirtdf2_pkg::TAP_BITS-1:0]   i_tap,
    input  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] i_x,
    input  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] i_y,
    input  logic signed [iirtdf2_pkg::TAP_BITS-1:0]   i_z_in,
    output logic signed [iirtdf2_pkg::TAP_BITS-1:0]   o_z,
    output logic                                      o_sat
);
    import iirtdf2_pkg::*;

    logic signed [COEF_BITS-1:0] r_b;
    logic signed [COEF_BITS-1:0] r_a;
    logic signed [TAP_BITS-1:0]  r_z;
    logic signed [PROD_BITS-1:0] r_pb;
    logic signed [PROD_BITS-1:0] r_pa;
    logic signed [SUM_BITS-1:0]  w_sum;
    logic signed [TAP_BITS-1:0]  n_z;
    logic                        w_ovf;

    always_comb begin
        w_sum = SUM_BITS'(r_pb) - SUM_BITS'(r_pa);
        if (!i_ctrl.last) begin
            w_sum = w_sum + SUM_BITS'(i_z_in);
        end
        w_ovf = !((&w_sum[SUM_BITS-1:TAP_BITS-1]) || !(|w_sum[SUM_BITS-1:TAP_BITS-1]));
        if (!w_ovf) begin
            n_z = w_sum[TAP_BITS-1:0];
        end else if (w_sum[SUM_BITS-1]) begin
            n_z = {1'b1, {(TAP_BITS-1){1'b0}}};
        end else begin
            n_z = {1'b0, {(TAP_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b <= '0;
            r_a <= '0;
            r_z <= '0;
        end else begin
            if (i_ctrl.we_b) begin
                r_b <= i_coef;
            end
            if (i_ctrl.we_a) begin
                r_a <= i_coef;
            end
            if (i_ctrl.we_z) begin
                r_z <= i_tap;
            end else if (i_ctrl.update && i_ctrl.active) begin
                r_z <= n_z;
            end
        end
    end

    // products held between the two multiply steps and the tap update
    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_x) begin
            r_pb <= r_b * i_x;
        end
        if (i_ctrl.mul_y) begin
            r_pa <= r_a * i_y;
        end
    end

    assign o_z   = r_z;
    assign o_sat = i_ctrl.active & w_ovf;

endmodule

FILE: hw/rtl/iirtdf2_head.sv
module iirtdf2_head (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  iirtdf2_pkg::t_head_ctrl                    i_ctrl,
    input  logic signed [iirtdf2_pkg::COEF_BITS-1:0]   i_coef,
    input  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] i_x,
    input  logic signed [iirtdf2_pkg::TAP_BITS-1:0]    i_z0,
    output logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] o_y,
    output logic                                       o_y_sat
);
    import iirtdf2_pkg::*;

    localparam logic signed [SUM_BITS-1:0] HALF = SUM_BITS'(1) << (FRAC_BITS - 1);

    logic signed [COEF_BITS-1:0]   r_b0;
    logic signed [PROD_BITS-1:0]   r_p0;
    logic signed [SAMPLE_BITS-1:0] r_y;
    logic                          r_y_sat;
    logic signed [SUM_BITS-1:0]    w_acc;
    logic signed [QUO_BITS-1:0]    w_quo;
    logic signed [SAMPLE_BITS-1:0] n_y;
    logic                          w_ovf;

    always_comb begin
        w_acc = SUM_BITS'(r_p0) + SUM_BITS'(i_z0) + HALF;
        w_quo = w_acc[SUM_BITS-1:FRAC_BITS];
        w_ovf = !((&w_quo[QUO_BITS-1:SAMPLE_BITS-1]) || !(|w_quo[QUO_BITS-1:SAMPLE_BITS-1]));
        if (!w_ovf) begin
            n_y = w_quo[SAMPLE_BITS-1:0];
        end else if (w_quo[QUO_BITS-1]) begin
            n_y = {1'b1, {(SAMPLE_BITS-1){1'b0}}};
        end else begin
            n_y = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b0 <= '0;
        end else if (i_ctrl.we_b0) begin
            r_b0 <= i_coef;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.mul_x) begin
            r_p0 <= r_b0 * i_x;
        end
        if (i_ctrl.calc_y) begin
            r_y     <= n_y;
            r_y_sat <= w_ovf;
        end
    end

    assign o_y     = r_y;
    assign o_y_sat = r_y_sat;

endmodule

FILE: hw/rtl/iir_transposed_df2_filter.sv
// a sample item runs the multiply, round, multiply, update sequence through the row of
//   tap cells before its result is registered; a tap read passes through the read state;
//   a new item is accepted only when idle, so one at a time; a write every cycle
// a waiting result does not block acceptance until the next result is ready to load
// reset (synchronous, active low) clears coefficients and taps and sets the order to 2
module iir_transposed_df2_filter (
    input  logic                                       i_clk,
    input  logic                                       i_rst_n,
    input  logic                                       i_cfg_we,
    input  logic [iirtdf2_pkg::ORDER_BITS-1:0]         i_cfg_data,
    input  logic                                       i_valid,
    output logic                                       o_ready,
    input  logic [iirtdf2_pkg::FUNC_BITS-1:0]          i_func,
    input  logic [iirtdf2_pkg::SLOT_BITS-1:0]          i_slot,
    input  logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] i_sample_in,
    input  logic signed [iirtdf2_pkg::COEF_BITS-1:0]   i_coef_value,
    input  logic signed [iirtdf2_pkg::TAP_BITS-1:0]    i_tap_value,
    output logic                                       o_valid,
    input  logic                                       i_ready,
    output logic                                       o_result_kind,
    output logic signed [iirtdf2_pkg::SAMPLE_BITS-1:0] o_sample_out,
    output logic signed [iirtdf2_pkg::TAP_BITS-1:0]    o_tap_out,
    output logic                                       o_saturated
);
    import iirtdf2_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MULX,
        S_Y,
        S_MULY,
        S_UPD,
        S_RD
    } t_state;

    t_state                        r_state;
    logic [ORDER_BITS-1:0]         r_order;
    logic signed [SAMPLE_BITS-1:0] r_x;
    logic [SLOT_BITS-1:0]          r_slot;
    logic                          r_out_valid;
    logic                          r_kind;
    logic signed [SAMPLE_BITS-1:0] r_sample;
    logic signed [TAP_BITS-1:0]    r_tap;
    logic                          r_sat;

    logic                          w_accept;
    logic                          w_out_free;
    logic                          w_load;
    t_func                         w_func;
    logic [CMP_BITS-1:0]           w_ord;
    logic [CMP_BITS-1:0]           w_slot;
    t_cell_ctrl                    w_ctrl [MAX_ORDER];
    t_head_ctrl                    w_hctrl;
    logic signed [TAP_BITS-1:0]    w_z [MAX_ORDER+1];
    logic [MAX_ORDER-1:0]          w_cell_sat;
    logic signed [SAMPLE_BITS-1:0] w_y;
    logic                          w_y_sat;
    logic signed [TAP_BITS-1:0]    w_rd;

    assign o_ready    = (r_state == S_IDLE);
    assign w_accept   = i_valid & o_ready;
    assign w_out_free = !r_out_valid || i_ready;
    assign w_load     = ((r_state == S_UPD) || (r_state == S_RD)) && w_out_free;
    assign w_func     = t_func'(i_func);
    assign w_slot     = CMP_BITS'(i_slot);

    always_comb begin
        if (r_order == '0) begin
            w_ord = CMP_BITS'(1);
        end else if (CMP_BITS'(r_order) > CMP_BITS'(MAX_ORDER)) begin
            w_ord = CMP_BITS'(MAX_ORDER);
        end else begin
            w_ord = CMP_BITS'(r_order);
        end
    end

    always_comb begin
        w_hctrl.we_b0  = w_accept && (w_func == FUNC_WR_B) && (w_slot == '0);
        w_hctrl.mul_x  = (r_state == S_MULX);
        w_hctrl.calc_y = (r_state == S_Y);
        for (int k = 0; k < MAX_ORDER; k++) begin
            w_ctrl[k].we_b   = w_accept && (w_func == FUNC_WR_B)
                               && (w_slot == CMP_BITS'(k + 1));
            w_ctrl[k].we_a   = w_accept && (w_func == FUNC_WR_A)
                               && (w_slot == CMP_BITS'(k + 1));
            w_ctrl[k].we_z   = w_accept && (w_func == FUNC_WR_TAP)
                               && (w_slot == CMP_BITS'(k));
            w_ctrl[k].mul_x  = (r_state == S_MULX);
            w_ctrl[k].mul_y  = (r_state == S_MULY);
            w_ctrl[k].update = (r_state == S_UPD) && w_out_free;
            w_ctrl[k].active = CMP_BITS'(k) < w_ord;
            w_ctrl[k].last   = CMP_BITS'(k) == (w_ord - CMP_BITS'(1));
        end
    end

    iirtdf2_head u_head (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (w_hctrl),
        .i_coef  (i_coef_value),
        .i_x     (r_x),
        .i_z0    (w_z[0]),
        .o_y     (w_y),
        .o_y_sat (w_y_sat)
    );

    assign w_z[MAX_ORDER] = '0;

    for (genvar k = 0; k < MAX_ORDER; k++) begin : g_cell
        iirtdf2_cell u_cell (
            .i_clk  (i_clk),
            .i_rst_n(i_rst_n),
            .i_ctrl (w_ctrl[k]),
            .i_coef (i_coef_value),
            .i_tap  (i_tap_value),
            .i_x    (r_x),
            .i_y    (w_y),
            .i_z_in (w_z[k+1]),
            .o_z    (w_z[k]),
            .o_sat  (w_cell_sat[k])
        );
    end

    always_comb begin
        w_rd = '0;
        for (int k = 0; k < MAX_ORDER; k++) begin
            if (CMP_BITS'(r_slot) == CMP_BITS'(k)) begin
                w_rd = w_z[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_order <= ORDER_RESET;
        end else if (i_cfg_we) begin
            r_order <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_x    <= i_sample_in;
            r_slot <= i_slot;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (i_ready && !w_load) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_accept && (w_func == FUNC_FILTER)) begin
                        r_state <= S_MULX;
                    end else if (w_accept && (w_func == FUNC_RD_TAP)) begin
                        r_state <= S_RD;
                    end
                end
                S_MULX: r_state <= S_Y;
                S_Y:    r_state <= S_MULY;
                S_MULY: r_state <= S_UPD;
                S_UPD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_SAMPLE;
                        r_sample    <= w_y;
                        r_tap       <= '0;
                        r_sat       <= w_y_sat | (|w_cell_sat);
                        r_state     <= S_IDLE;
                    end
                end
                S_RD: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_kind      <= KIND_TAP;
                        r_sample    <= '0;
                        r_tap       <= w_rd;
                        r_sat       <= 1'b0;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_out_valid;
    assign o_result_kind = r_kind;
    assign o_sample_out  = r_sample;
    assign o_tap_out     = r_tap;
    assign o_saturated   = r_sat;

    a_filter_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_func == FUNC_FILTER)) |=> (r_state == S_MULX) ##3 (r_state == S_UPD))
        else $error("sample item did not follow the multiply and update sequence");

    a_read_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_accept && (w_func == FUNC_RD_TAP)) |=> (r_state == S_RD))
        else $error("tap read did not enter the read state");

    a_upd_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && w_out_free) |=> (o_valid && (o_result_kind == KIND_SAMPLE)))
        else $error("tap update without a sample result");

    a_read_fields: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_TAP)) |-> ((o_sample_out == '0) && !o_saturated))
        else $error("tap readback carries sample fields");

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == S_UPD) && !w_out_free) |=> (r_state == S_UPD))
        else $error("update left while the output was still full");

endmodule

FILE: tb/sv/testbench.sv
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import iirtdf2_pkg::*;

    localparam longint CYCLE_LIMIT   = 1_000_000;
    localparam int     SETTLE_CYCLES = 8;
    localparam int     TOTAL_ITEMS   = 1500;
    localparam int     NUM_PHASES    = 8;
    localparam int     TAP_IDX_BITS  = $clog2(MAX_ORDER);

    localparam logic signed [COEF_BITS-1:0]   COEF_MAX   = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic signed [COEF_BITS-1:0]   COEF_MIN   = {1'b1, {(COEF_BITS-1){1'b0}}};
    localparam logic signed [COEF_BITS-1:0]   COEF_HALF  = COEF_BITS'(1) << (FRAC_BITS - 1);
    localparam logic signed [TAP_BITS-1:0]    TAP_MAX    = {1'b0, {(TAP_BITS-1){1'b1}}};
    localparam logic signed [TAP_BITS-1:0]    TAP_MIN    = {1'b1, {(TAP_BITS-1){1'b0}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    class filter_scoreboard;
        typedef struct {
            logic                          kind;
            logic signed [SAMPLE_BITS-1:0] sample;
            logic signed [TAP_BITS-1:0]    tap;
            logic                          sat;
        } filter_result_t;

        logic [ORDER_BITS-1:0]       order_reg;
        logic signed [COEF_BITS-1:0] b_coef [MAX_ORDER+1];
        logic signed [COEF_BITS-1:0] a_coef [MAX_ORDER+1];
        logic signed [TAP_BITS-1:0]  taps [MAX_ORDER];
        filter_result_t              pending_results [$];
        int                          errors;
        int                          n_samples;
        int                          n_reads;
        int                          n_sat;

        function new();
            order_reg = ORDER_RESET;
            foreach (b_coef[j]) begin
                b_coef[j] = '0;
                a_coef[j] = '0;
            end
            foreach (taps[j]) taps[j] = '0;
        endfunction

        function void set_order(logic [ORDER_BITS-1:0] value);
            order_reg = value;
        endfunction

        function longint clamp(longint v, int bits, inout bit hit);
            longint hi;
            longint lo;
            hi = (longint'(1) <<< (bits - 1)) - 1;
            lo = -hi - 1;
            if (v > hi) begin
                hit = 1'b1;
                return hi;
            end
            if (v < lo) begin
                hit = 1'b1;
                return lo;
            end
            return v;
        endfunction

        function void note_item(logic [FUNC_BITS-1:0] func, logic [SLOT_BITS-1:0] slot,
                                logic signed [SAMPLE_BITS-1:0] sample_in,
                                logic signed [COEF_BITS-1:0] coef,
                                logic signed [TAP_BITS-1:0] tap_in);
            filter_result_t r;
            longint         x;
            longint         acc;
            longint         y;
            longint         v;
            longint         next_taps [MAX_ORDER];
            int             ord;
            bit             hit;
            r.kind   = KIND_SAMPLE;
            r.sample = '0;
            r.tap    = '0;
            r.sat    = 1'b0;
            case (func)
                FUNC_FILTER: begin
                    ord = (order_reg == 0) ? 1 :
                          (order_reg > MAX_ORDER) ? MAX_ORDER : int'(order_reg);
                    hit = 1'b0;
                    x   = longint'(sample_in);
                    acc = longint'(b_coef[0]) * x + longint'(taps[0]);
                    y   = clamp((acc + (longint'(1) <<< (FRAC_BITS - 1))) >>> FRAC_BITS,
                                SAMPLE_BITS, hit);
                    for (int j = 1; j <= ord; j++) begin
                        v = longint'(b_coef[j]) * x - longint'(a_coef[j]) * y;
                        if (j < ord) v += longint'(taps[j]);
                        next_taps[j-1] = clamp(v, TAP_BITS, hit);
                    end
                    for (int j = 0; j < ord; j++) taps[j] = TAP_BITS'(next_taps[j]);
                    r.sample = SAMPLE_BITS'(y);
                    r.sat    = hit;
                    n_samples++;
                    if (hit) n_sat++;
                    pending_results.push_back(r);
                end
                FUNC_WR_B: if (slot <= MAX_ORDER) b_coef[slot] = coef;
                FUNC_WR_A: if (slot <= MAX_ORDER) a_coef[slot] = coef;
                FUNC_WR_TAP: if (slot < MAX_ORDER) taps[slot[TAP_IDX_BITS-1:0]] = tap_in;
                FUNC_RD_TAP: begin
                    r.kind = KIND_TAP;
                    if (slot < MAX_ORDER) r.tap = taps[slot[TAP_IDX_BITS-1:0]];
                    n_reads++;
                    pending_results.push_back(r);
                end
                default: ;
            endcase
        endfunction

        function void check_result(logic kind, logic signed [SAMPLE_BITS-1:0] sample,
                                   logic signed [TAP_BITS-1:0] tap, logic sat);
            filter_result_t want;
            if (pending_results.size() == 0) begin
                errors++;
                $display("%0t: unexpected result, kind %b sample %0d tap %0d saturated %b",
                         $time, kind, sample, tap, sat);
                return;
            end
            want = pending_results.pop_front();
            if (kind !== want.kind) begin
                errors++;
                $display("%0t: result_kind expected %b actual %b", $time, want.kind, kind);
            end
            if (sample !== want.sample) begin
                errors++;
                $display("%0t: sample_out expected %0d actual %0d", $time, want.sample, sample);
            end
            if (tap !== want.tap) begin
                errors++;
                $display("%0t: tap_out expected %0d actual %0d", $time, want.tap, tap);
            end
            if (sat !== want.sat) begin
                errors++;
                $display("%0t: saturated expected %b actual %b", $time, want.sat, sat);
            end
        endfunction
    endclass

    logic                          i_clk        = 1'b0;
    logic                          i_rst_n      = 1'b0;
    logic                          i_cfg_we     = 1'b0;
    logic [ORDER_BITS-1:0]         i_cfg_data   = '0;
    logic                          i_valid      = 1'b0;
    logic                          o_ready;
    logic [FUNC_BITS-1:0]          i_func       = '0;
    logic [SLOT_BITS-1:0]          i_slot       = '0;
    logic signed [SAMPLE_BITS-1:0] i_sample_in  = '0;
    logic signed [COEF_BITS-1:0]   i_coef_value = '0;
    logic signed [TAP_BITS-1:0]    i_tap_value  = '0;
    logic                          o_valid;
    logic                          i_ready      = 1'b0;
    logic                          o_result_kind;
    logic signed [SAMPLE_BITS-1:0] o_sample_out;
    logic signed [TAP_BITS-1:0]    o_tap_out;
    logic                          o_saturated;

    filter_scoreboard sb;
    int               tx_level    = 1;
    int               rx_level    = 1;
    int               rx_hold     = 0;
    int               n_sent      = 0;
    int               n_orders    = 0;
    longint           cycle_count = 0;

    iir_transposed_df2_filter i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_func        (i_func),
        .i_slot        (i_slot),
        .i_sample_in   (i_sample_in),
        .i_coef_value  (i_coef_value),
        .i_tap_value   (i_tap_value),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_result_kind (o_result_kind),
        .o_sample_out  (o_sample_out),
        .o_tap_out     (o_tap_out),
        .o_saturated   (o_saturated)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    function automatic int pick_gap(int level);
        int r;
        if (level == 0) return 0;
        r = $urandom_range(99);
        if (r < 70 - 20 * level) return 0;
        if (r < 95) return $urandom_range(1, 3 * level);
        return $urandom_range(10, 40);
    endfunction

    // result side: check, then decide whether to stall
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            sb.check_result(o_result_kind, o_sample_out, o_tap_out, o_saturated);
        end
        if (rx_hold != 0) begin
            i_ready <= 1'b0;
            rx_hold--;
        end else begin
            rx_hold = pick_gap(rx_level);
            i_ready <= (rx_hold == 0);
            if (rx_hold != 0) rx_hold--;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d results outstanding",
                     cycle_count, sb.pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(logic [FUNC_BITS-1:0] func, logic [SLOT_BITS-1:0] slot,
                             logic signed [SAMPLE_BITS-1:0] sample_in,
                             logic signed [COEF_BITS-1:0] coef,
                             logic signed [TAP_BITS-1:0] tap_in);
        int gap;
        gap = pick_gap(tx_level);
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_func       <= func;
        i_slot       <= slot;
        i_sample_in  <= sample_in;
        i_coef_value <= coef;
        i_tap_value  <= tap_in;
        do @(posedge i_clk); while (!o_ready);
        sb.note_item(func, slot, sample_in, coef, tap_in);
        if (func <= FUNC_RD_TAP) n_sent++;
    endtask

    task automatic drain_results();
        i_valid <= 1'b0;
        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_order(logic [ORDER_BITS-1:0] value);
        drain_results();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        sb.set_order(value);
        n_orders++;
    endtask

    // a moderate coefficient set and cleared taps, so the filter does real work
    task automatic load_filter(int ord);
        logic signed [COEF_BITS-1:0] c;
        for (int j = 0; j <= ord; j++) begin
            c = $urandom;
            send_item(FUNC_WR_B, SLOT_BITS'(j), SAMPLE_BITS'($urandom), c >>> 9,
                      TAP_BITS'({$urandom, $urandom}));
        end
        for (int j = 0; j <= ord; j++) begin
            c = $urandom;
            send_item(FUNC_WR_A, SLOT_BITS'(j), SAMPLE_BITS'($urandom), c >>> 10,
                      TAP_BITS'({$urandom, $urandom}));
        end
        for (int j = 0; j < ord; j++) begin
            send_item(FUNC_WR_TAP, SLOT_BITS'(j), SAMPLE_BITS'($urandom), $urandom, '0);
        end
    endtask

    task automatic random_item(int ord);
        int                            pick;
        logic [SLOT_BITS-1:0]          slot;
        logic signed [SAMPLE_BITS-1:0] sample;
        logic signed [COEF_BITS-1:0]   coef;
        logic signed [TAP_BITS-1:0]    tap;
        pick   = $urandom_range(99);
        slot   = ($urandom_range(3) == 0) ? SLOT_BITS'($urandom) : SLOT_BITS'($urandom_range(ord));
        sample = SAMPLE_BITS'($urandom);
        if ($urandom_range(1) != 0) sample = sample >>> $urandom_range(4, 14);
        coef = $urandom;
        if ($urandom_range(9) != 0) coef = coef >>> $urandom_range(6, 10);
        tap = TAP_BITS'({$urandom, $urandom});
        if ($urandom_range(3) != 0) tap = tap >>> $urandom_range(8, 20);
        if (pick < 60) send_item(FUNC_FILTER, slot, sample, coef, tap);
        else if (pick < 70) send_item(FUNC_WR_B, slot, sample, coef, tap);
        else if (pick < 78) send_item(FUNC_WR_A, slot, sample, coef, tap);
        else if (pick < 83) send_item(FUNC_WR_TAP, slot, sample, coef, tap);
        else if (pick < 97) send_item(FUNC_RD_TAP, slot, sample, coef, tap);
        else send_item(FUNC_BITS'($urandom_range(FUNC_RD_TAP + 1, (1 << FUNC_BITS) - 1)),
                       slot, sample, coef, tap);
    endtask

    initial begin
        logic [ORDER_BITS-1:0] phase_orders [NUM_PHASES];
        int                    ord;
        int                    target;
        phase_orders = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd3, 4'd5, 4'd2, 4'd7};
        sb = new();
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset order of 2: rounding, sample extremes, saturation, slot limits
        send_item(FUNC_RD_TAP, 0, 0, 0, 0);
        send_item(FUNC_WR_B, 0, 0, COEF_HALF, 0);
        send_item(FUNC_FILTER, 0, 1, 0, 0);
        send_item(FUNC_FILTER, 0, -1, 0, 0);
        send_item(FUNC_FILTER, 0, SAMPLE_MAX, 0, 0);
        send_item(FUNC_FILTER, 0, SAMPLE_MIN, 0, 0);
        send_item(FUNC_WR_B, 0, 0, COEF_MAX, 0);
        send_item(FUNC_FILTER, 0, SAMPLE_MAX, 0, 0);
        send_item(FUNC_FILTER, 0, SAMPLE_MIN, 0, 0);
        send_item(FUNC_WR_B, 1, 0, COEF_MIN, 0);
        send_item(FUNC_WR_B, 2, 0, COEF_MAX, 0);
        send_item(FUNC_WR_A, 0, 0, COEF_MAX, 0);
        send_item(FUNC_WR_A, 1, 0, COEF_MAX, 0);
        send_item(FUNC_WR_A, 2, 0, COEF_MIN, 0);
        send_item(FUNC_FILTER, 0, 1, 0, 0);
        send_item(FUNC_RD_TAP, 0, 0, 0, 0);
        send_item(FUNC_WR_TAP, 0, 0, 0, TAP_MAX);
        send_item(FUNC_WR_TAP, 1, 0, 0, TAP_MIN);
        send_item(FUNC_FILTER, 0, SAMPLE_MIN, 0, 0);
        send_item(FUNC_WR_B, 9, 0, COEF_MAX, 0);
        send_item(FUNC_WR_TAP, 8, 0, 0, TAP_MAX);
        send_item(FUNC_RD_TAP, 1, 0, 0, 0);
        send_item(FUNC_RD_TAP, 8, 0, 0, 0);
        send_item(FUNC_RD_TAP, 15, 0, 0, 0);
        for (int f = FUNC_RD_TAP + 1; f < (1 << FUNC_BITS); f++) begin
            send_item(FUNC_BITS'(f), 0, SAMPLE_MAX, COEF_MAX, TAP_MAX);
        end

        for (int p = 0; p < NUM_PHASES; p++) begin
            write_order(phase_orders[p]);
            ord = (phase_orders[p] == 0) ? 1 :
                  (phase_orders[p] > MAX_ORDER) ? MAX_ORDER : int'(phase_orders[p]);
            tx_level = (p == 0) ? 0 : $urandom_range(2);
            rx_level = (p == 0) ? 0 : $urandom_range(2);
            target   = n_sent + TOTAL_ITEMS / NUM_PHASES;
            load_filter(ord);
            while (n_sent < target) begin
                random_item(ord);
                if ($urandom_range(59) == 0) load_filter(ord);
                if ($urandom_range(299) == 0) drain_results();
            end
        end
        drain_results();

        $display("%0d items over %0d order settings: %0d samples filtered, %0d tap reads",
                 n_sent, n_orders, sb.n_samples, sb.n_reads);
        $display("%0d filtered samples saturated, %0d mismatches", sb.n_sat, sb.errors);
        if (sb.errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

FILE: sim.f
hw/rtl/iirtdf2_pkg.sv
hw/rtl/iirtdf2_cell.sv
hw/rtl/iirtdf2_head.sv
hw/rtl/iir_transposed_df2_filter.sv
tb/sv/testbench.sv
